// ===== rtl/stg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stabilizer tableau package
// Request, gate, error and pass codes, the command passed to the tableau,
// and the tables that expand each gate into elementary H, S or CNOT passes.
// ----------------------------------------------------------------------------
package stg_pkg;

    // Width of a qubit index compare and of the effective qubit count.
    localparam int QIDX_W = 6;
    localparam int EFF_W  = 7;

    // Request types.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_GATE  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Gate kinds.
    localparam logic [2:0] GATE_H    = 3'd0;
    localparam logic [2:0] GATE_S    = 3'd1;
    localparam logic [2:0] GATE_SDG  = 3'd2;
    localparam logic [2:0] GATE_X    = 3'd3;
    localparam logic [2:0] GATE_Y    = 3'd4;
    localparam logic [2:0] GATE_Z    = 3'd5;
    localparam logic [2:0] GATE_CNOT = 3'd6;

    // Error codes.
    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_CONTROLLED  = 3'd1;
    localparam logic [2:0] ERR_SAME_QUBITS = 3'd2;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ERR_RANGE       = 3'd4;

    // Elementary pass codes.
    typedef logic [1:0] t_op;
    localparam t_op OP_H    = 2'd0;
    localparam t_op OP_S    = 2'd1;
    localparam t_op OP_CNOT = 2'd2;

    // Command from the sequencer to the tableau.
    typedef struct packed {
        logic       clear;
        logic       op_valid;
        t_op        op;
        logic [4:0] tgt;
        logic [4:0] ctl;
    } t_tab_cmd;

    // Number of elementary passes of a gate.
    function automatic logic [2:0] stg_seq_len(input logic [2:0] kind);
        logic [2:0] len;
        case (kind)
            GATE_H:    len = 3'd1;
            GATE_S:    len = 3'd1;
            GATE_SDG:  len = 3'd3;
            GATE_X:    len = 3'd4;
            GATE_Y:    len = 3'd6;
            GATE_Z:    len = 3'd2;
            GATE_CNOT: len = 3'd1;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    // Pass to run at a given step of a gate: X is H S S H, Y is H S S H S S.
    function automatic t_op stg_seq_op(input logic [2:0] kind, input logic [2:0] step);
        t_op op;
        case (kind)
            GATE_H:    op = OP_H;
            GATE_X,
            GATE_Y:    op = (step inside {3'd0, 3'd3}) ? OP_H : OP_S;
            GATE_CNOT: op = OP_CNOT;
            default:   op = OP_S;
        endcase
        return op;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/stg_rows.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stabilizer tableau rows
// Holds the X, Z and phase bits of every row and applies one elementary
// H, S or CNOT pass to all active rows in parallel. Also serves row reads.
// ----------------------------------------------------------------------------
module stg_rows
    import stg_pkg::*;
#(
    parameter int MAX_QUBITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_tab_cmd              i_cmd,
    input  wire logic [EFF_W-1:0]      i_eff,
    input  wire logic [4:0]            i_rd_row,
    output logic [MAX_QUBITS-1:0]      o_rd_x,
    output logic [MAX_QUBITS-1:0]      o_rd_z,
    output logic                       o_rd_p
);

    logic [MAX_QUBITS-1:0] r_x [MAX_QUBITS];
    logic [MAX_QUBITS-1:0] r_z [MAX_QUBITS];
    logic [MAX_QUBITS-1:0] r_p;

    // One-hot column masks for the target and the control qubit.
    logic [MAX_QUBITS-1:0] w_mask_t;
    logic [MAX_QUBITS-1:0] w_mask_c;

    always_comb begin
        for (int j = 0; j < MAX_QUBITS; j++) begin
            w_mask_t[j] = ({1'b0, i_cmd.tgt} == QIDX_W'(j));
            w_mask_c[j] = ({1'b0, i_cmd.ctl} == QIDX_W'(j));
        end
    end

    // Each row updates itself from its own bits on the selected columns.
    for (genvar i = 0; i < MAX_QUBITS; i++) begin : g_row
        localparam logic [MAX_QUBITS-1:0] ROW_IDENT = (MAX_QUBITS)'(1) << i;

        logic                  w_en;
        logic                  w_xt;
        logic                  w_zt;
        logic                  w_xc;
        logic                  w_zc;
        logic [MAX_QUBITS-1:0] n_x;
        logic [MAX_QUBITS-1:0] n_z;
        logic                  n_p;

        assign w_en = (EFF_W'(i) < i_eff);
        assign w_xt = |(r_x[i] & w_mask_t);
        assign w_zt = |(r_z[i] & w_mask_t);
        assign w_xc = |(r_x[i] & w_mask_c);
        assign w_zc = |(r_z[i] & w_mask_c);

        // Next row value for the pass on this cycle.
        always_comb begin
            n_x = r_x[i];
            n_z = r_z[i];
            n_p = r_p[i];
            if (i_cmd.op_valid && w_en) begin
                case (i_cmd.op)
                    OP_H: begin
                        n_p = r_p[i] ^ (w_xt & w_zt);
                        n_x = (r_x[i] & ~w_mask_t) | (w_zt ? w_mask_t : '0);
                        n_z = (r_z[i] & ~w_mask_t) | (w_xt ? w_mask_t : '0);
                    end
                    OP_S: begin
                        n_p = r_p[i] ^ (w_xt & w_zt);
                        n_z = r_z[i] ^ (w_xt ? w_mask_t : '0);
                    end
                    OP_CNOT: begin
                        n_p = r_p[i] ^ (w_xc & w_zt & (w_xt == w_zc));
                        n_z = r_z[i] ^ (w_zt ? w_mask_c : '0);
                        n_x = r_x[i] ^ (w_xc ? w_mask_t : '0);
                    end
                    default: begin
                        n_p = r_p[i];
                    end
                endcase
            end
        end

        // Reset and clear both load the identity row.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_cmd.clear) begin
                r_x[i] <= '0;
                r_z[i] <= ROW_IDENT;
                r_p[i] <= 1'b0;
            end else begin
                r_x[i] <= n_x;
                r_z[i] <= n_z;
                r_p[i] <= n_p;
            end
        end
    end

    // Row read port.
    always_comb begin
        o_rd_x = '0;
        o_rd_z = '0;
        o_rd_p = 1'b0;
        for (int r = 0; r < MAX_QUBITS; r++) begin
            if ({1'b0, i_rd_row} == QIDX_W'(r)) begin
                o_rd_x = o_rd_x | r_x[r];
                o_rd_z = o_rd_z | r_z[r];
                o_rd_p = o_rd_p | r_p[r];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/stg_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stabilizer tableau sequencer
// Checks each request, steps a gate through its elementary passes one per
// cycle, and holds the result item in the output register.
// ----------------------------------------------------------------------------
module stg_seq
    import stg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [1:0]       i_req_type,
    input  wire logic [2:0]       i_gate_kind,
    input  wire logic [1:0]       i_control_count,
    input  wire logic [4:0]       i_target_qubit,
    input  wire logic [4:0]       i_control_qubit,
    input  wire logic [4:0]       i_row_select,
    input  wire logic [EFF_W-1:0] i_eff,
    input  wire logic [31:0]      i_rd_x,
    input  wire logic [31:0]      i_rd_z,
    input  wire logic             i_rd_p,
    output t_tab_cmd              o_cmd,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [31:0]           o_row_x_bits,
    output logic [31:0]           o_row_z_bits,
    output logic                  o_row_phase,
    output logic [2:0]            o_elementary_steps,
    output logic [2:0]            o_error_code
);

    logic       r_busy;
    logic [2:0] r_kind;
    logic [2:0] r_step;
    logic [2:0] r_len;
    logic [4:0] r_tgt;
    logic [4:0] r_ctl;
    logic       r_out_valid;
    logic [31:0] r_x;
    logic [31:0] r_z;
    logic        r_p;
    logic [2:0]  r_steps;
    logic [2:0]  r_err;

    logic       w_accept;
    logic       w_last;
    logic       w_tgt_bad;
    logic       w_ctl_bad;
    logic       w_start;
    logic       w_clear;
    logic [2:0] w_err;
    logic       w_rd_ok;

    assign o_in_ready = !r_busy && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_last     = r_busy && ((r_step + 3'd1) == r_len);
    assign w_tgt_bad  = ({2'b00, i_target_qubit} >= i_eff);
    assign w_ctl_bad  = ({2'b00, i_control_qubit} >= i_eff);

    // Request check: decides start of a gate run, a clear, a row read, or the error code.
    always_comb begin
        w_start = 1'b0;
        w_clear = 1'b0;
        w_rd_ok = 1'b0;
        w_err   = ERR_OK;
        case (i_req_type)
            REQ_CLEAR: begin
                w_clear = 1'b1;
            end
            REQ_GATE: begin
                if (i_gate_kind == GATE_CNOT) begin
                    if (i_control_count != 2'd1) begin
                        w_err = ERR_UNSUPPORTED;
                    end else if (w_tgt_bad || w_ctl_bad) begin
                        w_err = ERR_RANGE;
                    end else if (i_target_qubit == i_control_qubit) begin
                        w_err = ERR_SAME_QUBITS;
                    end else begin
                        w_start = 1'b1;
                    end
                end else if (stg_seq_len(i_gate_kind) == 3'd0) begin
                    w_err = ERR_UNSUPPORTED;
                end else if (i_control_count != 2'd0) begin
                    w_err = ERR_CONTROLLED;
                end else if (w_tgt_bad) begin
                    w_err = ERR_RANGE;
                end else begin
                    w_start = 1'b1;
                end
            end
            REQ_READ: begin
                if ({2'b00, i_row_select} >= i_eff) begin
                    w_err = ERR_RANGE;
                end else begin
                    w_rd_ok = 1'b1;
                end
            end
            default: begin
                w_err = ERR_UNSUPPORTED;
            end
        endcase
    end

    // Pass and clear issued to the tableau.
    always_comb begin
        o_cmd.clear    = w_accept && w_clear;
        o_cmd.op_valid = r_busy;
        o_cmd.op       = stg_seq_op(r_kind, r_step);
        o_cmd.tgt      = r_tgt;
        o_cmd.ctl      = r_ctl;
    end

    // Sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (w_accept && w_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_busy <= !w_last;
            r_step <= r_step + 3'd1;
        end
    end

    // Gate operands, captured when a run starts.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_start) begin
            r_kind <= i_gate_kind;
            r_len  <= stg_seq_len(i_gate_kind);
            r_tgt  <= i_target_qubit;
            r_ctl  <= i_control_qubit;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_accept && !w_start) || w_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: direct results load at accept, gate results at the last pass.
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_start) begin
            r_x     <= w_rd_ok ? i_rd_x : '0;
            r_z     <= w_rd_ok ? i_rd_z : '0;
            r_p     <= w_rd_ok && i_rd_p;
            r_steps <= '0;
            r_err   <= w_err;
        end else if (w_last) begin
            r_x     <= '0;
            r_z     <= '0;
            r_p     <= 1'b0;
            r_steps <= r_len;
            r_err   <= ERR_OK;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_row_x_bits       = r_x;
    assign o_row_z_bits       = r_z;
    assign o_row_phase        = r_p;
    assign o_elementary_steps = r_steps;
    assign o_error_code       = r_err;

endmodule
`default_nettype wire

// ===== rtl/stabilizer_tableau_gate_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stabilizer tableau gate update
// Clifford stabilizer tableau with clear, gate and row read requests.
// ----------------------------------------------------------------------------
// The block keeps a tableau of MAX_QUBITS rows of X bits, Z bits and a phase
// bit, of which the first qubit_count rows are active. A clear, a row read
// and any rejected request load their result item into the output register
// when accepted. A gate is expanded into elementary H, S or CNOT passes that
// run one per cycle, each applied to all active rows at once by per-row logic,
// so a gate takes 1 (H, S, CNOT), 2 (Z), 3 (Sdag), 4 (X) or 6 (Y) passes; its
// result item appears in the output register after the last pass, and the
// next item is taken in the following cycle once that result has been taken
// or is being taken. After a change of qubit_count, issue a clear.
// ----------------------------------------------------------------------------
module stabilizer_tableau_gate_update
    import stg_pkg::*;
#(
    parameter int MAX_QUBITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Request channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [2:0]  i_gate_kind,
    input  wire logic [1:0]  i_control_count,
    input  wire logic [4:0]  i_target_qubit,
    input  wire logic [4:0]  i_control_qubit,
    input  wire logic [4:0]  i_row_select,
    // Result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_row_x_bits,
    output logic [31:0]      o_row_z_bits,
    output logic             o_row_phase,
    output logic [2:0]       o_elementary_steps,
    output logic [2:0]       o_error_code
);

    logic [5:0]            r_qubit_count;
    logic [EFF_W-1:0]      w_eff;
    t_tab_cmd              w_cmd;
    logic [MAX_QUBITS-1:0] w_rd_x;
    logic [MAX_QUBITS-1:0] w_rd_z;
    logic                  w_rd_p;
    logic [31:0]           w_rd_x32;
    logic [31:0]           w_rd_z32;

    // Register file: qubit_count at address 0.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qubit_count <= 6'd32;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_qubit_count <= pwdata[5:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {26'd0, r_qubit_count} : '0;

    // Effective qubit count: zero acts as one, large values saturate.
    always_comb begin
        if (r_qubit_count == '0) begin
            w_eff = EFF_W'(1);
        end else if ({1'b0, r_qubit_count} > EFF_W'(MAX_QUBITS)) begin
            w_eff = EFF_W'(MAX_QUBITS);
        end else begin
            w_eff = {1'b0, r_qubit_count};
        end
    end

    // Fit the row read data to the 32-bit result fields.
    if (MAX_QUBITS >= 32) begin : g_rd_trunc
        assign w_rd_x32 = w_rd_x[31:0];
        assign w_rd_z32 = w_rd_z[31:0];
    end else begin : g_rd_ext
        assign w_rd_x32 = {{(32 - MAX_QUBITS){1'b0}}, w_rd_x};
        assign w_rd_z32 = {{(32 - MAX_QUBITS){1'b0}}, w_rd_z};
    end

    stg_seq u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_gate_kind        (i_gate_kind),
        .i_control_count    (i_control_count),
        .i_target_qubit     (i_target_qubit),
        .i_control_qubit    (i_control_qubit),
        .i_row_select       (i_row_select),
        .i_eff              (w_eff),
        .i_rd_x             (w_rd_x32),
        .i_rd_z             (w_rd_z32),
        .i_rd_p             (w_rd_p),
        .o_cmd              (w_cmd),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_row_x_bits       (o_row_x_bits),
        .o_row_z_bits       (o_row_z_bits),
        .o_row_phase        (o_row_phase),
        .o_elementary_steps (o_elementary_steps),
        .o_error_code       (o_error_code)
    );

    stg_rows #(
        .MAX_QUBITS (MAX_QUBITS)
    ) u_rows (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_eff    (w_eff),
        .i_rd_row (i_row_select),
        .o_rd_x   (w_rd_x),
        .o_rd_z   (w_rd_z),
        .o_rd_p   (w_rd_p)
    );

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stabilizer tableau gate update testbench
// Drives clear, gate and row read requests through the valid/ready request
// channel, tracks its own copy of the X/Z/phase tableau and checks every
// result item in order. The qubit count is changed over APB between phases.
// ----------------------------------------------------------------------------
module tb;
    import stg_pkg::*;

    // Codes the package does not name.
    localparam logic [1:0] REQ_RESERVED     = 2'd3;
    localparam logic [2:0] GATE_UNSUP       = 3'd7;
    localparam logic [2:0] ADDR_QUBIT_COUNT = 3'd0;
    localparam int         ROWS             = 32;

    typedef struct packed {
        logic [1:0] req;
        logic [2:0] kind;
        logic [1:0] ctrls;
        logic [4:0] tgt;
        logic [4:0] ctl;
        logic [4:0] row;
    } t_request;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] z;
        logic        phase;
        logic [2:0]  steps;
        logic [2:0]  err;
    } t_row_result;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    // Tableau tracker: mirrors the tableau and holds the results still owed.
    class tableau_tracker;
        bit [31:0]   x_rows[ROWS];
        bit [31:0]   z_rows[ROWS];
        bit          phase_bits[ROWS];
        bit [5:0]    qubit_reg;
        string       gate_recipe[6];
        t_row_result owed[$];
        int unsigned failures;
        int unsigned reported;
        int unsigned requests;
        int unsigned gates_applied;
        int unsigned rows_read;
        int unsigned rejected;

        function new();
            // Each single-qubit gate as a string of elementary passes.
            gate_recipe[GATE_H]   = "H";
            gate_recipe[GATE_S]   = "S";
            gate_recipe[GATE_SDG] = "SSS";
            gate_recipe[GATE_X]   = "HSSH";
            gate_recipe[GATE_Y]   = "HSSHSS";
            gate_recipe[GATE_Z]   = "SS";
            qubit_reg = 6'd32;
            set_identity();
        endfunction

        function void set_identity();
            for (int i = 0; i < ROWS; i++) begin
                x_rows[i]     = '0;
                z_rows[i]     = 32'd1 << i;
                phase_bits[i] = 1'b0;
            end
        endfunction

        // Out-of-range register values saturate into 1..ROWS.
        function int unsigned active_rows();
            if (qubit_reg == 0) return 1;
            if (qubit_reg > ROWS) return ROWS;
            return qubit_reg;
        endfunction

        function void col_h(int unsigned n, int unsigned a);
            bit xa, za;
            for (int unsigned i = 0; i < n; i++) begin
                xa = x_rows[i][a];
                za = z_rows[i][a];
                phase_bits[i] ^= xa & za;
                x_rows[i][a] = za;
                z_rows[i][a] = xa;
            end
        endfunction

        function void col_s(int unsigned n, int unsigned a);
            bit xa, za;
            for (int unsigned i = 0; i < n; i++) begin
                xa = x_rows[i][a];
                za = z_rows[i][a];
                phase_bits[i] ^= xa & za;
                z_rows[i][a] ^= xa;
            end
        endfunction

        function void col_cnot(int unsigned n, int unsigned c, int unsigned t);
            bit xc, zc, xt, zt;
            for (int unsigned i = 0; i < n; i++) begin
                xc = x_rows[i][c];
                zc = z_rows[i][c];
                xt = x_rows[i][t];
                zt = z_rows[i][t];
                phase_bits[i] ^= xc & zt & (xt ~^ zc);
                z_rows[i][c] ^= zt;
                x_rows[i][t] ^= xc;
            end
        endfunction

        // Apply an accepted request and queue the result it owes.
        function void accept_request(t_request r);
            t_row_result want;
            int unsigned n;
            string       recipe;
            want = '0;
            n = active_rows();
            requests++;
            case (r.req)
                REQ_CLEAR: begin
                    set_identity();
                end
                REQ_GATE: begin
                    if (r.kind == GATE_UNSUP) begin
                        want.err = ERR_UNSUPPORTED;
                    end else if (r.kind == GATE_CNOT) begin
                        if (r.ctrls != 2'd1) want.err = ERR_UNSUPPORTED;
                        else if (r.tgt >= n || r.ctl >= n) want.err = ERR_RANGE;
                        else if (r.tgt == r.ctl) want.err = ERR_SAME_QUBITS;
                        else begin
                            col_cnot(n, r.ctl, r.tgt);
                            want.steps = 3'd1;
                        end
                    end else if (r.ctrls != 2'd0) begin
                        want.err = ERR_CONTROLLED;
                    end else if (r.tgt >= n) begin
                        want.err = ERR_RANGE;
                    end else begin
                        recipe = gate_recipe[r.kind];
                        for (int k = 0; k < recipe.len(); k++) begin
                            if (recipe[k] == "H") col_h(n, r.tgt);
                            else col_s(n, r.tgt);
                        end
                        want.steps = 3'(recipe.len());
                    end
                end
                REQ_READ: begin
                    if (r.row >= n) begin
                        want.err = ERR_RANGE;
                    end else begin
                        want.x     = x_rows[r.row];
                        want.z     = z_rows[r.row];
                        want.phase = phase_bits[r.row];
                        rows_read++;
                    end
                end
                default: begin
                    want.err = ERR_UNSUPPORTED;
                end
            endcase
            if (want.steps != 0) gates_applied++;
            if (want.err != ERR_OK) rejected++;
            owed = {owed, want};
        endfunction

        // Compare a result item with the oldest owed result.
        function void compare_result(t_row_result got);
            t_row_result want;
            if (owed.size() == 0) begin
                failures++;
                if (reported < 10)
                    $display("Unexpected result item: x=%h z=%h ph=%b steps=%0d err=%0d",
                             got.x, got.z, got.phase, got.steps, got.err);
                reported++;
                return;
            end
            want = owed.pop_front();
            if (got.x !== want.x || got.z !== want.z || got.phase !== want.phase ||
                got.steps !== want.steps || got.err !== want.err) begin
                failures++;
                if (reported < 10) begin
                    $display("Mismatch: expected x=%h z=%h ph=%b steps=%0d err=%0d",
                             want.x, want.z, want.phase, want.steps, want.err);
                    $display("          got      x=%h z=%h ph=%b steps=%0d err=%0d",
                             got.x, got.z, got.phase, got.steps, got.err);
                end
                reported++;
            end
        endfunction
    endclass

    // DUT signals, all inputs known from time zero.
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [2:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type      = '0;
    logic [2:0]  i_gate_kind     = '0;
    logic [1:0]  i_control_count = '0;
    logic [4:0]  i_target_qubit  = '0;
    logic [4:0]  i_control_qubit = '0;
    logic [4:0]  i_row_select    = '0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [31:0] o_row_x_bits;
    logic [31:0] o_row_z_bits;
    logic        o_row_phase;
    logic [2:0]  o_elementary_steps;
    logic [2:0]  o_error_code;

    tableau_tracker tracker = new();
    int unsigned    settings_run = 1;
    t_rx_mode       rx_mode      = RX_STREAM;
    int unsigned    rx_left      = 0;
    logic [7:0]     rx_tick      = '0;

    stabilizer_tableau_gate_update uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_gate_kind        (i_gate_kind),
        .i_control_count    (i_control_count),
        .i_target_qubit     (i_target_qubit),
        .i_control_qubit    (i_control_qubit),
        .i_row_select       (i_row_select),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_row_x_bits       (o_row_x_bits),
        .o_row_z_bits       (o_row_z_bits),
        .o_row_phase        (o_row_phase),
        .o_elementary_steps (o_elementary_steps),
        .o_error_code       (o_error_code)
    );

    // Clock generation.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit: about 430 items end well within 5 ms, which leaves a wide margin.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side stalls in randomly chosen modes that change at random.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STREAM:   i_out_ready <= 1'b1;
            RX_MOSTLY:   i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE:   i_out_ready <= ($urandom_range(0, 3) == 0);
            default:     i_out_ready <= (rx_tick[2:0] == 3'd5);
        endcase
    end

    // Both channels are observed on the same edge, results first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                tracker.compare_result({o_row_x_bits, o_row_z_bits, o_row_phase,
                                        o_elementary_steps, o_error_code});
            if (i_in_valid && o_in_ready)
                tracker.accept_request({i_req_type, i_gate_kind, i_control_count,
                                        i_target_qubit, i_control_qubit, i_row_select});
        end
    end

    function automatic t_request mk(logic [1:0] req, logic [2:0] kind, logic [1:0] ctrls,
                                    logic [4:0] tgt, logic [4:0] ctl, logic [4:0] row);
        t_request r;
        r = '{req, kind, ctrls, tgt, ctl, row};
        return r;
    endfunction

    // Mostly well-formed gates and reads inside the active rows, plus noise.
    function automatic t_request rand_request(int unsigned n);
        t_request    r;
        int unsigned pick;
        r = t_request'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            r.req = REQ_CLEAR;
        end else if (pick < 28) begin
            r.req = REQ_READ;
            r.row = 5'($urandom_range(0, n - 1));
        end else if (pick < 83) begin
            r.req  = REQ_GATE;
            r.kind = 3'($urandom_range(0, 6));
            r.tgt  = 5'($urandom_range(0, n - 1));
            if (r.kind == GATE_CNOT) begin
                r.ctrls = 2'd1;
                r.ctl   = r.tgt;
                if (n > 1)
                    while (r.ctl == r.tgt) r.ctl = 5'($urandom_range(0, n - 1));
            end else begin
                r.ctrls = 2'd0;
            end
        end else if (pick < 86) begin
            r.req = REQ_RESERVED;
        end else begin
            r.req = 2'($urandom_range(1, 2));
        end
        return r;
    endfunction

    // Present one item and hold it until it is taken.
    task automatic send_item(t_request r);
        i_in_valid      <= 1'b1;
        i_req_type      <= r.req;
        i_gate_kind     <= r.kind;
        i_control_count <= r.ctrls;
        i_target_qubit  <= r.tgt;
        i_control_qubit <= r.ctl;
        i_row_select    <= r.row;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic idle_gap(int unsigned cycles);
        if (cycles != 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Random items in bursts with random gaps in between.
    task automatic run_random(int unsigned count);
        int unsigned burst;
        burst = $urandom_range(1, 12);
        for (int unsigned k = 0; k < count; k++) begin
            send_item(rand_request(tracker.active_rows()));
            burst--;
            if (burst == 0) begin
                idle_gap($urandom_range(0, 6));
                burst = $urandom_range(1, 12);
            end
        end
        idle_gap(1);
    endtask

    task automatic wait_drained();
        while (tracker.owed.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write of the qubit count; junk above the register width is ignored.
    task automatic write_qubit_count(logic [5:0] count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_QUBIT_COUNT;
        pwdata  <= {26'($urandom), count};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.qubit_reg = count;
        settings_run++;
    endtask

    // Directed items at the full width of 32 qubits.
    task automatic run_directed_full();
        t_request items[$];
        items = '{
            mk(REQ_READ, GATE_H, 2'd0, 5'd0, 5'd0, 5'd0),
            mk(REQ_READ, GATE_H, 2'd0, 5'd0, 5'd0, 5'd31),
            mk(REQ_GATE, GATE_H, 2'd0, 5'd0, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_S, 2'd0, 5'd0, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_SDG, 2'd0, 5'd31, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_X, 2'd0, 5'd5, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_Y, 2'd0, 5'd31, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_Z, 2'd0, 5'd0, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_CNOT, 2'd1, 5'd31, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_CNOT, 2'd1, 5'd0, 5'd31, 5'd0),
            mk(REQ_READ, GATE_H, 2'd0, 5'd0, 5'd0, 5'd0),
            mk(REQ_READ, GATE_H, 2'd0, 5'd0, 5'd0, 5'd31),
            mk(REQ_READ, GATE_H, 2'd0, 5'd0, 5'd0, 5'd5),
            // Unsupported kind wins over controls; controls win over range.
            mk(REQ_GATE, GATE_UNSUP, 2'd3, 5'd31, 5'd31, 5'd0),
            mk(REQ_GATE, GATE_H, 2'd3, 5'd0, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_Z, 2'd1, 5'd2, 5'd0, 5'd0),
            // CNOT needs exactly one control and distinct qubits.
            mk(REQ_GATE, GATE_CNOT, 2'd0, 5'd1, 5'd2, 5'd0),
            mk(REQ_GATE, GATE_CNOT, 2'd2, 5'd1, 5'd2, 5'd0),
            mk(REQ_GATE, GATE_CNOT, 2'd1, 5'd7, 5'd7, 5'd0),
            mk(REQ_RESERVED, GATE_UNSUP, 2'd3, 5'd31, 5'd31, 5'd31),
            mk(REQ_CLEAR, GATE_UNSUP, 2'd3, 5'd31, 5'd31, 5'd31),
            mk(REQ_READ, GATE_H, 2'd0, 5'd0, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_Y, 2'd0, 5'd0, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_H, 2'd0, 5'd0, 5'd0, 5'd0),
            mk(REQ_READ, GATE_H, 2'd0, 5'd0, 5'd0, 5'd0)
        };
        foreach (items[k]) begin
            send_item(items[k]);
            if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 5));
        end
        idle_gap(1);
    endtask

    // Directed range checks with a single active qubit.
    task automatic run_directed_single();
        t_request items[$];
        items = '{
            mk(REQ_GATE, GATE_H, 2'd0, 5'd0, 5'd0, 5'd0),
            mk(REQ_READ, GATE_H, 2'd0, 5'd0, 5'd0, 5'd0),
            mk(REQ_READ, GATE_H, 2'd0, 5'd0, 5'd0, 5'd1),
            mk(REQ_READ, GATE_H, 2'd0, 5'd0, 5'd0, 5'd31),
            mk(REQ_GATE, GATE_X, 2'd0, 5'd31, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_CNOT, 2'd1, 5'd0, 5'd1, 5'd0),
            mk(REQ_GATE, GATE_CNOT, 2'd1, 5'd31, 5'd31, 5'd0),
            mk(REQ_GATE, GATE_CNOT, 2'd1, 5'd0, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_S, 2'd2, 5'd31, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_CNOT, 2'd3, 5'd31, 5'd0, 5'd0),
            mk(REQ_GATE, GATE_Y, 2'd0, 5'd0, 5'd0, 5'd0),
            mk(REQ_READ, GATE_H, 2'd0, 5'd0, 5'd0, 5'd0)
        };
        foreach (items[k]) send_item(items[k]);
        idle_gap(1);
    endtask

    // Main sequence: reset, directed items, then random phases per setting.
    initial begin
        logic [5:0] settings[$];
        settings = '{6'd1, 6'd0, 6'd63, 6'd5, 6'd17, 6'($urandom_range(2, 31))};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed_full();
        run_random(70);
        foreach (settings[k]) begin
            wait_drained();
            write_qubit_count(settings[k]);
            if ($urandom_range(0, 1) == 0) begin
                send_item(mk(REQ_CLEAR, 3'($urandom), 2'($urandom), 5'($urandom),
                             5'($urandom), 5'($urandom)));
                idle_gap(1);
            end
            if (settings[k] == 6'd0) run_directed_single();
            run_random(55);
        end
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d requests over %0d qubit counts: %0d gates applied,",
                 tracker.requests, settings_run, tracker.gates_applied);
        $display("%0d rows read and %0d requests rejected.",
                 tracker.rows_read, tracker.rejected);
        if (tracker.failures != 0 || tracker.owed.size() != 0)
            $display("%0d bad result items, %0d results never arrived.",
                     tracker.failures, tracker.owed.size());
        if (tracker.failures == 0 && tracker.owed.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/stg_pkg.sv
rtl/stg_rows.sv
rtl/stg_seq.sv
rtl/stabilizer_tableau_gate_update.sv
bench/tb.sv
